@@ hdl/bdd_pkg.sv @@
package bdd_pkg;

    localparam int COORD_FRAC  = 4;
    localparam int EXP_DEPTH   = 256;
    localparam int EXP_BITS    = $clog2(EXP_DEPTH);
    localparam int WORK_EXTRA  = 14;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam longint unsigned LN2_Q32 = 64'd2977044472;
    localparam logic signed [18:0] OUT_MAX = 19'sd262143;
    localparam logic signed [18:0] OUT_MIN = -19'sd262144;

    // register indexes
    localparam logic [2:0] CFG_MEAN_CENTER   = 3'd0;
    localparam logic [2:0] CFG_MEAN_SIZE     = 3'd1;
    localparam logic [2:0] CFG_STD_CENTER    = 3'd2;
    localparam logic [2:0] CFG_STD_SIZE      = 3'd3;
    localparam logic [2:0] CFG_MAX_LOG_RATIO = 3'd4;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd6;
    localparam logic [2:0] CFG_CLIP_ENABLE   = 3'd7;

    typedef struct packed {
        logic signed [15:0] mean_center;
        logic signed [15:0] mean_size;
        logic [15:0]        std_center;
        logic [15:0]        std_size;
        logic [14:0]        max_log_ratio;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic               clip_enable;
    } t_cfg;

    // denormalized item handed from front to back
    typedef struct packed {
        logic [15:0]        x_tl;
        logic [15:0]        y_tl;
        logic [15:0]        x_br;
        logic [15:0]        y_br;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [15:0] dw;
        logic signed [15:0] dh;
    } t_work;

    typedef logic [31:0] t_exp_tab [0:EXP_DEPTH];

    // restoring division for the table series
    function automatic longint unsigned udiv_series(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(k/depth) in q.30, series evaluation, round to nearest
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab        t;
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        for (int k = 0; k <= EXP_DEPTH; k++) begin
            x    = (longint'(k) * LN2_Q32) >> EXP_BITS;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int i = 1; i <= 24; i++) begin
                term = (term * x) >> 32;
                term = udiv_series(term, longint'(i));
                sum  = sum + term;
            end
            t[k] = 32'((sum + 64'd2) >> 2);
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

@@ hdl/bdd_intf.sv @@
interface bdd_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        roi_x_tl;
    logic [15:0]        roi_y_tl;
    logic [15:0]        roi_x_br;
    logic [15:0]        roi_y_br;
    logic signed [15:0] delta_dx;
    logic signed [15:0] delta_dy;
    logic signed [15:0] delta_dw;
    logic signed [15:0] delta_dh;
    modport source(output valid, roi_x_tl, roi_y_tl, roi_x_br, roi_y_br,
                   delta_dx, delta_dy, delta_dw, delta_dh, input ready);
    modport sink(input valid, roi_x_tl, roi_y_tl, roi_x_br, roi_y_br,
                 delta_dx, delta_dy, delta_dw, delta_dh, output ready);
endinterface

interface bdd_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] box_x_tl;
    logic signed [18:0] box_y_tl;
    logic signed [18:0] box_x_br;
    logic signed [18:0] box_y_br;
    modport source(output valid, box_x_tl, box_y_tl, box_x_br, box_y_br, input ready);
    modport sink(input valid, box_x_tl, box_y_tl, box_x_br, box_y_br, output ready);
endinterface

interface bdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/bdd_front.sv @@
module bdd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdd_pkg::t_cfg  i_cfg,
    bdd_in_if.sink         i_in,
    output logic           o_push_valid,
    output bdd_pkg::t_work o_work,
    input  logic           i_push_ready
);

    logic               r_v;
    logic [15:0]        r_c [4];
    logic signed [15:0] r_d [4];
    logic               take;

    logic signed [32:0] prod [4];
    logic signed [17:0] den  [4];
    logic signed [17:0] lim;
    logic signed [15:0] dw_c;
    logic signed [15:0] dh_c;

    assign i_in.ready = !r_v || i_push_ready;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
        if (take) begin
            r_c[0] <= i_in.roi_x_tl;
            r_c[1] <= i_in.roi_y_tl;
            r_c[2] <= i_in.roi_x_br;
            r_c[3] <= i_in.roi_y_br;
            r_d[0] <= i_in.delta_dx;
            r_d[1] <= i_in.delta_dy;
            r_d[2] <= i_in.delta_dw;
            r_d[3] <= i_in.delta_dh;
        end
    end

    // scale by std (floor), add mean, clamp dw and dh to +-max_log_ratio
    always_comb begin
        prod[0] = r_d[0] * $signed({1'b0, i_cfg.std_center});
        prod[1] = r_d[1] * $signed({1'b0, i_cfg.std_center});
        prod[2] = r_d[2] * $signed({1'b0, i_cfg.std_size});
        prod[3] = r_d[3] * $signed({1'b0, i_cfg.std_size});
        den[0]  = 18'(prod[0] >>> 16) + 18'(i_cfg.mean_center);
        den[1]  = 18'(prod[1] >>> 16) + 18'(i_cfg.mean_center);
        den[2]  = 18'(prod[2] >>> 16) + 18'(i_cfg.mean_size);
        den[3]  = 18'(prod[3] >>> 16) + 18'(i_cfg.mean_size);
        lim     = $signed({3'b000, i_cfg.max_log_ratio});
        if (den[2] > lim)       dw_c = 16'(lim);
        else if (den[2] < -lim) dw_c = 16'(-lim);
        else                    dw_c = 16'(den[2]);
        if (den[3] > lim)       dh_c = 16'(lim);
        else if (den[3] < -lim) dh_c = 16'(-lim);
        else                    dh_c = 16'(den[3]);
    end

    assign o_push_valid = r_v;
    assign o_work = '{x_tl: r_c[0], y_tl: r_c[1], x_br: r_c[2], y_br: r_c[3],
                      dx: den[0], dy: den[1], dw: dw_c, dh: dh_c};

endmodule

@@ hdl/bdd_queue.sv @@
module bdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  bdd_pkg::t_work i_work,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output bdd_pkg::t_work o_work,
    input  logic           i_pop_ready
);

    bdd_pkg::t_work                  r_mem [bdd_pkg::Q_DEPTH];
    logic [bdd_pkg::Q_PTR_W-1:0]     r_wptr;
    logic [bdd_pkg::Q_PTR_W-1:0]     r_rptr;
    logic [bdd_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                            push;
    logic                            pop;

    assign o_push_ready = r_cnt != bdd_pkg::Q_CNT_W'(bdd_pkg::Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_work       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
        if (push) r_mem[r_wptr] <= i_work;
    end

endmodule

@@ hdl/bdd_back.sv @@
module bdd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdd_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  bdd_pkg::t_work i_work,
    output logic           o_ready,
    bdd_out_if.source      o_out
);

    localparam int UP = bdd_pkg::WORK_EXTRA - 1;

    // stage 1: sizes, center sums, exponent
    logic               r_v1;
    logic signed [17:0] r1_pw, r1_ph;
    logic [16:0]        r1_sx, r1_sy;
    logic signed [17:0] r1_dx, r1_dy;
    logic signed [21:0] r1_yw, r1_yh;
    // stage 2: centers, mantissas
    logic               r_v2;
    logic signed [17:0] r2_pw, r2_ph;
    logic signed [39:0] r2_cx, r2_cy;
    logic [31:0]        r2_mw, r2_mh;
    logic signed [5:0]  r2_iw, r2_ih;
    // stage 3: size times mantissa
    logic               r_v3;
    logic signed [50:0] r3_pmw, r3_pmh;
    logic signed [39:0] r3_cx, r3_cy;
    logic signed [5:0]  r3_iw, r3_ih;
    // stage 4: rounded corners
    logic               r_v4;
    logic signed [37:0] r4_r [4];
    // output register
    logic               r_ov;
    logic signed [18:0] r_box [4];

    logic rdy1, rdy2, rdy3, rdy4, rdy_o;

    assign rdy_o   = !r_ov || o_out.ready;
    assign rdy4    = !r_v4 || rdy_o;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // stage 1 logic
    logic signed [33:0] ew, eh;
    always_comb begin
        ew = i_work.dw * 18'sd94548;
        eh = i_work.dh * 18'sd94548;
    end

    // stage 2 logic
    logic [15:0]        frw, frh;
    logic [bdd_pkg::EXP_BITS-1:0] ixw, ixh;
    logic [15:0]        rmw, rmh;
    logic [31:0]        low, hiw, loh, hih;
    logic [47:0]        ipw, iph;
    logic signed [35:0] ox, oy;
    always_comb begin
        frw = r1_yw[15:0];
        frh = r1_yh[15:0];
        ixw = frw[15 -: bdd_pkg::EXP_BITS];
        ixh = frh[15 -: bdd_pkg::EXP_BITS];
        rmw = frw << bdd_pkg::EXP_BITS;
        rmh = frh << bdd_pkg::EXP_BITS;
        low = bdd_pkg::EXP_TAB[ixw];
        hiw = bdd_pkg::EXP_TAB[{1'b0, ixw} + 1'b1];
        loh = bdd_pkg::EXP_TAB[ixh];
        hih = bdd_pkg::EXP_TAB[{1'b0, ixh} + 1'b1];
        ipw = (hiw - low) * rmw;
        iph = (hih - loh) * rmh;
        ox  = r1_pw * r1_dx;
        oy  = r1_ph * r1_dy;
    end

    // stage 4 logic
    logic [4:0]         shw, shh;
    logic signed [50:0] hw, hh;
    logic signed [51:0] cx, cy, hp, v [4];
    always_comb begin
        shw = 5'(7'sd17 - 7'(r3_iw));
        shh = 5'(7'sd17 - 7'(r3_ih));
        hw  = r3_pmw >>> shw;
        hh  = r3_pmh >>> shh;
        cx  = 52'(r3_cx);
        cy  = 52'(r3_cy);
        hp  = 52'sd1 <<< (bdd_pkg::COORD_FRAC + UP);
        v[0] = cx - 52'(hw) + hp;
        v[1] = cy - 52'(hh) + hp;
        v[2] = cx + 52'(hw) - hp;
        v[3] = cy + 52'(hh) - hp;
    end

    function automatic logic signed [18:0] finish(input logic signed [37:0] r,
                                                  input logic [12:0] dim,
                                                  input logic clip);
        logic [12:0]        d1;
        logic signed [37:0] lim;
        logic signed [37:0] c;
        d1  = (dim == '0) ? 13'd1 : dim;
        lim = $signed(38'(d1 - 13'd1) << bdd_pkg::COORD_FRAC);
        c   = r;
        if (clip) begin
            if (c < 0)        c = '0;
            else if (c > lim) c = lim;
        end
        if (c > 38'(bdd_pkg::OUT_MAX))      return bdd_pkg::OUT_MAX;
        else if (c < 38'(bdd_pkg::OUT_MIN)) return bdd_pkg::OUT_MIN;
        else                                return 19'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1)  r_v1 <= i_valid;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy3)  r_v3 <= r_v2;
            if (rdy4)  r_v4 <= r_v3;
            if (rdy_o) r_ov <= r_v4;
        end
        if (rdy1 && i_valid) begin
            r1_pw <= $signed({2'b00, i_work.x_br}) - $signed({2'b00, i_work.x_tl})
                     + (18'sd1 <<< bdd_pkg::COORD_FRAC);
            r1_ph <= $signed({2'b00, i_work.y_br}) - $signed({2'b00, i_work.y_tl})
                     + (18'sd1 <<< bdd_pkg::COORD_FRAC);
            r1_sx <= {1'b0, i_work.x_tl} + {1'b0, i_work.x_br};
            r1_sy <= {1'b0, i_work.y_tl} + {1'b0, i_work.y_br};
            r1_dx <= i_work.dx;
            r1_dy <= i_work.dy;
            r1_yw <= 22'(ew >>> 12);
            r1_yh <= 22'(eh >>> 12);
        end
        if (rdy2 && r_v1) begin
            r2_pw <= r1_pw;
            r2_ph <= r1_ph;
            r2_cx <= ($signed({23'd0, r1_sx}) <<< UP)
                     + (40'(ox) <<< (bdd_pkg::WORK_EXTRA - 12));
            r2_cy <= ($signed({23'd0, r1_sy}) <<< UP)
                     + (40'(oy) <<< (bdd_pkg::WORK_EXTRA - 12));
            r2_mw <= low + ipw[47:16];
            r2_mh <= loh + iph[47:16];
            r2_iw <= r1_yw[21:16];
            r2_ih <= r1_yh[21:16];
        end
        if (rdy3 && r_v2) begin
            r3_pmw <= 51'(r2_pw * $signed({1'b0, r2_mw}));
            r3_pmh <= 51'(r2_ph * $signed({1'b0, r2_mh}));
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
            r3_iw  <= r2_iw;
            r3_ih  <= r2_ih;
        end
        if (rdy4 && r_v3) begin
            for (int k = 0; k < 4; k++) begin
                r4_r[k] <= 38'((v[k] + (52'sd1 <<< (bdd_pkg::WORK_EXTRA - 1)))
                               >>> bdd_pkg::WORK_EXTRA);
            end
        end
        if (rdy_o && r_v4) begin
            r_box[0] <= finish(r4_r[0], i_cfg.image_width,  i_cfg.clip_enable);
            r_box[1] <= finish(r4_r[1], i_cfg.image_height, i_cfg.clip_enable);
            r_box[2] <= finish(r4_r[2], i_cfg.image_width,  i_cfg.clip_enable);
            r_box[3] <= finish(r4_r[3], i_cfg.image_height, i_cfg.clip_enable);
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.box_x_tl = r_box[0];
    assign o_out.box_y_tl = r_box[1];
    assign o_out.box_x_br = r_box[2];
    assign o_out.box_y_br = r_box[3];

endmodule

@@ hdl/box_delta_decode_top.sv @@
// channel   dir  beat contents
// i_in      in   anchor corners (q12.4) and four raw deltas (q4.12)
// o_out     out  four decoded corners, signed q14.4, clipped or saturated
// i_cfg     in   register index and write data
//
// one beat per cycle sustained while the consumer keeps o_out ready; the path from input
// to output runs through the front register, queue, four back stages, output register
// the queue is four beats deep, so the front keeps taking beats while the
// back is stalled by the consumer until the queue fills
// reset is synchronous, clears all valid flags and loads register defaults
// i_cfg is always ready; a write takes effect on the next cycle
module box_delta_decode_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bdd_in_if.sink   i_in,
    bdd_out_if.source o_out,
    bdd_cfg_if.sink  i_cfg
);

    bdd_pkg::t_cfg  r_cfg;
    logic           push_valid;
    logic           push_ready;
    bdd_pkg::t_work push_work;
    logic           pop_valid;
    logic           pop_ready;
    bdd_pkg::t_work pop_work;

    // register file, writes always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mean_center   <= 16'sd0;
            r_cfg.mean_size     <= 16'sd0;
            r_cfg.std_center    <= 16'd6554;
            r_cfg.std_size      <= 16'd13107;
            r_cfg.max_log_ratio <= 15'd16937;
            r_cfg.image_width   <= 13'd1024;
            r_cfg.image_height  <= 13'd1024;
            r_cfg.clip_enable   <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bdd_pkg::CFG_MEAN_CENTER:   r_cfg.mean_center   <= $signed(i_cfg.data);
                bdd_pkg::CFG_MEAN_SIZE:     r_cfg.mean_size     <= $signed(i_cfg.data);
                bdd_pkg::CFG_STD_CENTER:    r_cfg.std_center    <= i_cfg.data;
                bdd_pkg::CFG_STD_SIZE:      r_cfg.std_size      <= i_cfg.data;
                bdd_pkg::CFG_MAX_LOG_RATIO: r_cfg.max_log_ratio <= i_cfg.data[14:0];
                bdd_pkg::CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg.data[12:0];
                bdd_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg.data[12:0];
                bdd_pkg::CFG_CLIP_ENABLE:   r_cfg.clip_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // front: accept the beat, denormalize the deltas and clamp the size deltas
    bdd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_work       (push_work),
        .i_push_ready (push_ready)
    );

    // short queue decoupling front and back stalls
    bdd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_work       (push_work),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_work       (pop_work),
        .i_pop_ready  (pop_ready)
    );

    // back: centers, table exp, corners, clip and saturate
    bdd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pop_valid),
        .i_work  (pop_work),
        .o_ready (pop_ready),
        .o_out   (o_out)
    );

endmodule
